>>> rtl/core/sih_pkg.sv
// Shared constants, opcodes, status codes and cell link type for the sorted insert histogram.
package sih_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int GRADE_MAX_DEF = 127;

    localparam logic [1:0] OP_INSERT     = 2'd0;
    localparam logic [1:0] OP_READ_ENTRY = 2'd1;
    localparam logic [1:0] OP_READ_COUNT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_INDEX = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // status a cell hands to the cell above it
    typedef struct packed {
        logic vld;    // cell holds a grade
        logic yield;  // cell gives up its place to the new grade (empty or greater)
    } cell_link_t;

endpackage

>>> rtl/core/sih_if.sv
// Request and response channel interfaces.
interface sih_req_if #(
    parameter int GW = 7,
    parameter int IW = 6
);
    logic          valid;
    logic          ready;
    logic [1:0]    opcode;
    logic [GW-1:0] grade_in;
    logic [IW-1:0] entry_index;

    modport source (output valid, opcode, grade_in, entry_index, input ready);
    modport sink   (input valid, opcode, grade_in, entry_index, output ready);
endinterface

interface sih_rsp_if #(
    parameter int GW = 7,
    parameter int CW = 7
);
    logic               valid;
    logic               ready;
    logic [GW-1:0]      value_out;
    logic [CW-1:0]      count_out;
    logic signed [GW:0] largest;
    logic [CW-1:0]      fill_level;
    logic [1:0]         status;

    modport source (output valid, value_out, count_out, largest, fill_level, status,
                    input ready);
    modport sink   (input valid, value_out, count_out, largest, fill_level, status,
                    output ready);
endinterface

>>> rtl/core/sih_cell.sv
// One place of the sorted list: keeps, takes the new grade, or takes its lower neighbor's grade.
module sih_cell
    import sih_pkg::*;
#(
    parameter int GW = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ins,
    input  logic [GW-1:0] grade,
    input  cell_link_t    prev_link,
    input  logic [GW-1:0] prev_val,
    output cell_link_t    link,
    output logic [GW-1:0] val
);

    logic          vld_reg;
    logic [GW-1:0] val_reg;

    assign link.vld   = vld_reg;
    assign link.yield = !vld_reg || (val_reg > grade);
    assign val        = val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ins && link.yield)
        begin
            // yield flags are monotone along the row; the first yielding cell takes the grade
            vld_reg <= prev_link.yield ? prev_link.vld : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins && link.yield)
        begin
            val_reg <= prev_link.yield ? prev_val : grade;
        end
    end

endmodule

>>> rtl/core/sih_bin_store.sv
// Per-grade count memory with valid bits so that unwritten bins read as zero.
module sih_bin_store
    import sih_pkg::*;
#(
    parameter int DEPTH = GRADE_MAX_DEF + 1,
    parameter int AW    = 7,
    parameter int CW    = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [CW-1:0] wr_data,
    output logic [CW-1:0] rd_data
);

    logic [CW-1:0] mem [DEPTH];
    logic [DEPTH-1:0] bin_vld_reg;
    logic [CW-1:0] rdata_reg;
    logic          rvld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg <= '0;
            rvld_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                bin_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= bin_vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvld_reg ? rdata_reg : '0;

endmodule

>>> rtl/core/sorted_insert_histogram.sv
// Top level: sorted grade list in a row of cells, per-grade counts, running maximum.
//
//  channel | dir | words
//  --------+-----+-----------------------------------------------------------
//  req     | in  | opcode, grade_in, entry_index
//  rsp     | out | value_out, count_out, largest, fill_level, status
//
// Each word passes the states S_ADDR, S_DATA and S_OUT after acceptance, and req is ready
// again only once rsp is loaded, so no new word is taken while one is in process: the sorted
// entry is picked from the cell row at acceptance, the count store is read with registered
// data, the result and any insert are committed, then rsp is loaded.
// A new request is taken while the previous response still waits on rsp.
// Reset empties the cell row and clears all counts at once; largest reads -1.
// A stalled rsp holds the next result in its own register until rsp is free.
module sorted_insert_histogram
    import sih_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int GRADE_MAX = GRADE_MAX_DEF,
    localparam int GW = $clog2(GRADE_MAX + 1),
    localparam int IW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  logic      clk,
    input  logic      rst_n,
    sih_req_if.sink   req,
    sih_rsp_if.source rsp
);

    typedef enum logic [1:0] {S_IDLE, S_ADDR, S_DATA, S_OUT} state_t;

    state_t             state_reg;
    logic [1:0]         op_reg;
    logic [GW-1:0]      grade_reg;
    logic [IW-1:0]      index_reg;
    logic [GW-1:0]      entry_reg;
    logic [CW-1:0]      fill_reg;
    logic signed [GW:0] largest_reg;
    logic [GW-1:0]      res_value_reg;
    logic [CW-1:0]      res_count_reg;
    logic [1:0]         res_status_reg;
    logic               rsp_valid_reg;
    logic [GW-1:0]      rsp_value_reg;
    logic [CW-1:0]      rsp_count_reg;
    logic signed [GW:0] rsp_largest_reg;
    logic [CW-1:0]      rsp_fill_reg;
    logic [1:0]         rsp_status_reg;

    logic [GW-1:0]      res_value_next;
    logic [CW-1:0]      res_count_next;
    logic [1:0]         res_status_next;
    logic               ins;
    logic               range_bad;
    logic               full;
    logic               idx_bad;
    logic [CW-1:0]      bin_cnt;
    logic [GW-1:0]      rd_addr;
    logic               req_take;
    logic               rsp_load;

    cell_link_t         link [CAPACITY];
    logic [GW-1:0]      cell_val [CAPACITY];

    // ---------------- cell row ----------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_link_t    prev_link;
        logic [GW-1:0] prev_val;

        if (i == 0)
        begin : g_first
            assign prev_link = '{vld: 1'b0, yield: 1'b0};
            assign prev_val  = '0;
        end
        else
        begin : g_rest
            assign prev_link = link[i-1];
            assign prev_val  = cell_val[i-1];
        end

        sih_cell #(.GW(GW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ins       (ins),
            .grade     (grade_reg),
            .prev_link (prev_link),
            .prev_val  (prev_val),
            .link      (link[i]),
            .val       (cell_val[i])
        );
    end

    // ---------------- count store ----------------
    assign rd_addr = (op_reg == OP_READ_ENTRY) ? entry_reg : grade_reg;

    sih_bin_store #(.DEPTH(GRADE_MAX + 1), .AW(GW), .CW(CW)) u_bins (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (state_reg == S_ADDR),
        .rd_addr (rd_addr),
        .wr_en   (ins),
        .wr_addr (grade_reg),
        .wr_data (res_count_next),
        .rd_data (bin_cnt)
    );

    // ---------------- result ----------------
    assign range_bad = {1'b0, grade_reg} > (GW + 1)'(GRADE_MAX);
    assign full      = fill_reg == CW'(CAPACITY);
    assign idx_bad   = CW'(index_reg) >= fill_reg;

    always_comb
    begin
        res_value_next  = '0;
        res_count_next  = '0;
        res_status_next = ST_OK;
        ins             = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                res_value_next = grade_reg;
                if (range_bad)
                begin
                    res_status_next = ST_RANGE;
                end
                else if (full)
                begin
                    res_count_next  = bin_cnt;
                    res_status_next = ST_FULL;
                end
                else
                begin
                    res_count_next = CW'(bin_cnt + 1'b1);
                    ins            = (state_reg == S_DATA);
                end
            end
            OP_READ_ENTRY:
            begin
                if (idx_bad)
                begin
                    res_status_next = ST_INDEX;
                end
                else
                begin
                    res_value_next = entry_reg;
                    res_count_next = bin_cnt;
                end
            end
            OP_READ_COUNT:
            begin
                res_value_next = grade_reg;
                if (range_bad)
                begin
                    res_status_next = ST_RANGE;
                end
                else
                begin
                    res_count_next = bin_cnt;
                end
            end
            default:
            begin
                res_value_next = '0;
            end
        endcase
    end

    assign req_take = req.valid && req.ready;
    assign rsp_load = (state_reg == S_OUT) && (!rsp_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_INSERT;
            grade_reg       <= '0;
            index_reg       <= '0;
            entry_reg       <= '0;
            fill_reg        <= '0;
            largest_reg     <= '1;
            res_value_reg   <= '0;
            res_count_reg   <= '0;
            res_status_reg  <= ST_OK;
            rsp_valid_reg   <= 1'b0;
            rsp_value_reg   <= '0;
            rsp_count_reg   <= '0;
            rsp_largest_reg <= '1;
            rsp_fill_reg    <= '0;
            rsp_status_reg  <= ST_OK;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && !rsp_load)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        op_reg    <= req.opcode;
                        grade_reg <= req.grade_in;
                        index_reg <= req.entry_index;
                        entry_reg <= cell_val[req.entry_index];
                        state_reg <= S_ADDR;
                    end
                end
                S_ADDR:
                begin
                    state_reg <= S_DATA;
                end
                S_DATA:
                begin
                    res_value_reg  <= res_value_next;
                    res_count_reg  <= res_count_next;
                    res_status_reg <= res_status_next;
                    if (ins)
                    begin
                        fill_reg <= CW'(fill_reg + 1'b1);
                        if ($signed({1'b0, grade_reg}) > largest_reg)
                        begin
                            largest_reg <= $signed({1'b0, grade_reg});
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (rsp_load)
                    begin
                        rsp_valid_reg   <= 1'b1;
                        rsp_value_reg   <= res_value_reg;
                        rsp_count_reg   <= res_count_reg;
                        rsp_largest_reg <= largest_reg;
                        rsp_fill_reg    <= fill_reg;
                        rsp_status_reg  <= res_status_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.value_out  = rsp_value_reg;
    assign rsp.count_out  = rsp_count_reg;
    assign rsp.largest    = rsp_largest_reg;
    assign rsp.fill_level = rsp_fill_reg;
    assign rsp.status     = rsp_status_reg;

endmodule
